// File: src/parallel_beam_geometry_gen_core_defines.svh
// assertion helpers shared by the geometry generator
`ifndef PARALLEL_BEAM_GEOMETRY_GEN_CORE_DEFINES_SVH
`define PARALLEL_BEAM_GEOMETRY_GEN_CORE_DEFINES_SVH

// same-cycle implication
`define PBG_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pbg_pkg.sv
`timescale 1ns / 1ps
package pbg_pkg;

  localparam int ANGLE_W    = 16;
  localparam int OFFSET_W   = 24;
  localparam int OFF_FRAC   = 12;
  localparam int COUNT_W    = 13;
  localparam int SIZE_W     = 24;
  localparam int HALF_W     = 37;
  localparam int HALF_LO_W  = 18;
  localparam int RAY_W      = 18;
  localparam int START_W    = 37;
  localparam int STEP_W     = 26;
  localparam int UX_W       = 28;
  localparam int SUM_W      = 40;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;
  localparam int WORK_W     = 32;
  localparam int WORK_FRAC  = 30;

  localparam int RAY_MAX  = 65536;
  localparam int STEP_MAX = 16777216;

  localparam logic signed [SUM_W-1:0] START_HI =
    {{(SUM_W-START_W+1){1'b0}}, {(START_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] START_LO = ~START_HI;

  localparam logic signed [WORK_W-1:0] GAIN_INV = 32'sd652032874;

  localparam logic [COUNT_W-1:0] DET_COUNT_RST = 13'd512;
  localparam logic [SIZE_W-1:0]  DET_SIZE_RST  = 24'd65536;
  localparam logic [HALF_W-1:0]  HALF_RST      =
    HALF_W'(DET_COUNT_RST) * HALF_W'(DET_SIZE_RST);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DET_COUNT = 8'd0,
    REG_DET_SIZE  = 8'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [WORK_W-1:0]   x;
    logic signed [WORK_W-1:0]   y;
    logic signed [WORK_W-1:0]   z;
    quad_e                      quad;
    logic signed [OFFSET_W-1:0] det_offset;
    logic                       last;
  } cordic_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic signed [WORK_W-1:0] atan_turn(input int unsigned idx);
    logic signed [WORK_W-1:0] v;
    case (idx)
      0:       v = 32'sd536870912;
      1:       v = 32'sd316933406;
      2:       v = 32'sd167458907;
      3:       v = 32'sd85004756;
      4:       v = 32'sd42667331;
      5:       v = 32'sd21354465;
      6:       v = 32'sd10679838;
      7:       v = 32'sd5340245;
      8:       v = 32'sd2670163;
      9:       v = 32'sd1335087;
      10:      v = 32'sd667544;
      11:      v = 32'sd333772;
      12:      v = 32'sd166886;
      13:      v = 32'sd83443;
      14:      v = 32'sd41722;
      15:      v = 32'sd20861;
      16:      v = 32'sd10430;
      17:      v = 32'sd5215;
      18:      v = 32'sd2608;
      19:      v = 32'sd1304;
      20:      v = 32'sd652;
      21:      v = 32'sd326;
      22:      v = 32'sd163;
      23:      v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/pbg_if.sv
`timescale 1ns / 1ps
interface pbg_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [pbg_pkg::ANGLE_W-1:0]          angle;
  logic signed [pbg_pkg::OFFSET_W-1:0]  det_offset;
  logic                                 last_view;

  modport source (output valid, angle, det_offset, last_view, input ready);
  modport sink (input valid, angle, det_offset, last_view, output ready);
endinterface

interface pbg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pbg_pkg::RAY_W-1:0]   ray_x;
  logic signed [pbg_pkg::RAY_W-1:0]   ray_y;
  logic signed [pbg_pkg::START_W-1:0] start_x;
  logic signed [pbg_pkg::START_W-1:0] start_y;
  logic signed [pbg_pkg::STEP_W-1:0]  step_x;
  logic signed [pbg_pkg::STEP_W-1:0]  step_y;
  logic                               last_out;

  modport source (output valid, ray_x, ray_y, start_x, start_y, step_x, step_y, last_out,
                  input ready);
  modport sink (input valid, ray_x, ray_y, start_x, start_y, step_x, step_y, last_out,
                output ready);
endinterface

interface pbg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pbg_pkg::CFG_IDX_W-1:0]    index;
  logic [pbg_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/pbg_cordic_cell.sv
`timescale 1ns / 1ps
module pbg_cordic_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  pbg_pkg::cordic_t data_i,
  output logic             valid_o,
  output pbg_pkg::cordic_t data_o
);

  localparam logic signed [pbg_pkg::WORK_W-1:0] ATAN = pbg_pkg::atan_turn(IDX);

  logic                              valid_q;
  pbg_pkg::cordic_t                  data_d;
  pbg_pkg::cordic_t                  data_q;
  logic signed [pbg_pkg::WORK_W-1:0] dx;
  logic signed [pbg_pkg::WORK_W-1:0] dy;

  always_comb begin
    dx     = data_i.y >>> IDX;
    dy     = data_i.x >>> IDX;
    data_d = data_i;
    // rotate toward zero residual angle
    if (!data_i.z[pbg_pkg::WORK_W-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - ATAN;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: src/pbg_scale.sv
`timescale 1ns / 1ps
module pbg_scale #(
  parameter  int FRAC_BITS = 16,
  localparam int CW        = FRAC_BITS + 3
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic signed [CW-1:0]                c_i,
  input  logic signed [CW-1:0]                s_i,
  input  logic signed [pbg_pkg::OFFSET_W-1:0] det_offset_i,
  input  logic                                last_i,
  input  logic [pbg_pkg::SIZE_W-1:0]          det_size_i,
  input  logic [pbg_pkg::HALF_W-1:0]          half_i,
  output logic                                valid_o,
  output logic signed [pbg_pkg::RAY_W-1:0]    ray_x_o,
  output logic signed [pbg_pkg::RAY_W-1:0]    ray_y_o,
  output logic signed [pbg_pkg::START_W-1:0]  start_x_o,
  output logic signed [pbg_pkg::START_W-1:0]  start_y_o,
  output logic signed [pbg_pkg::STEP_W-1:0]   step_x_o,
  output logic signed [pbg_pkg::STEP_W-1:0]   step_y_o,
  output logic                                last_o
);

  localparam int RSH  = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int LSH  = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int RQW  = CW + LSH + 1;
  localparam int PSW  = pbg_pkg::SIZE_W + 1 + CW;
  localparam int PLW  = pbg_pkg::HALF_LO_W + 1 + CW;
  localparam int PHW  = pbg_pkg::HALF_W - pbg_pkg::HALF_LO_W + 1 + CW;
  localparam int HCW  = pbg_pkg::HALF_W + 1 + CW;
  localparam int UW   = pbg_pkg::UX_W;
  localparam int OUW  = pbg_pkg::OFFSET_W + UW;
  localparam int SW   = pbg_pkg::SUM_W;
  localparam int PSX  = PSW + 1;
  localparam int HCX  = HCW + 1;
  localparam int OUX  = OUW + 1;

  // half-LSB rounding constants, zero when there is no shift
  localparam logic signed [RQW-1:0] RQ_RND = (RQW'(1) << RSH) >> 1;
  localparam logic signed [PSX-1:0] UX_RND = (PSX'(1) << FRAC_BITS) >> 1;
  localparam logic signed [HCX-1:0] HC_RND = (HCX'(1) << (FRAC_BITS + 1)) >> 1;
  localparam logic signed [OUX-1:0] OU_RND = (OUX'(1) << pbg_pkg::OFF_FRAC) >> 1;

  localparam logic signed [RQW-1:0] RAY_HI  = RQW'(pbg_pkg::RAY_MAX);
  localparam logic signed [RQW-1:0] RAY_LO  = -RAY_HI;
  localparam logic signed [UW-1:0]  STEP_HI = UW'(pbg_pkg::STEP_MAX);
  localparam logic signed [UW-1:0]  STEP_LO = -STEP_HI;

  logic [4:0] vld_q;

  // stage 1: products and ray
  logic signed [PSW-1:0]                psz_d [2];
  logic signed [PSW-1:0]                psz_q [2];
  logic signed [PLW-1:0]                plo_d [2];
  logic signed [PLW-1:0]                plo_q [2];
  logic signed [PHW-1:0]                phi_d [2];
  logic signed [PHW-1:0]                phi_q [2];
  logic signed [pbg_pkg::RAY_W-1:0]     ray1_d [2];
  logic signed [pbg_pkg::RAY_W-1:0]     ray1_q [2];
  logic signed [pbg_pkg::OFFSET_W-1:0]  off1_q;
  logic                                 last1_q;
  // stage 2: step and half-width product
  logic signed [UW-1:0]                 ux2_d [2];
  logic signed [UW-1:0]                 ux2_q [2];
  logic signed [HCW-1:0]                hc2_d [2];
  logic signed [HCW-1:0]                hc2_q [2];
  logic signed [pbg_pkg::RAY_W-1:0]     ray2_q [2];
  logic signed [pbg_pkg::OFFSET_W-1:0]  off2_q;
  logic                                 last2_q;
  // stage 3: offset product, rounded half width, clamped step
  logic signed [OUW-1:0]                ou3_d [2];
  logic signed [OUW-1:0]                ou3_q [2];
  logic signed [SW-1:0]                 hcr3_d [2];
  logic signed [SW-1:0]                 hcr3_q [2];
  logic signed [pbg_pkg::STEP_W-1:0]    step3_d [2];
  logic signed [pbg_pkg::STEP_W-1:0]    step3_q [2];
  logic signed [pbg_pkg::RAY_W-1:0]     ray3_q [2];
  logic                                 last3_q;
  // stage 4: rounded offset term
  logic signed [SW-1:0]                 ofr4_d [2];
  logic signed [SW-1:0]                 ofr4_q [2];
  logic signed [SW-1:0]                 hcr4_q [2];
  logic signed [pbg_pkg::STEP_W-1:0]    step4_q [2];
  logic signed [pbg_pkg::RAY_W-1:0]     ray4_q [2];
  logic                                 last4_q;
  // stage 5: output register
  logic signed [pbg_pkg::START_W-1:0]   start5_d [2];
  logic signed [pbg_pkg::START_W-1:0]   start5_q [2];
  logic signed [pbg_pkg::STEP_W-1:0]    step5_q [2];
  logic signed [pbg_pkg::RAY_W-1:0]     ray5_q [2];
  logic                                 last5_q;

  logic signed [CW-1:0]              vin [2];
  logic signed [RQW-1:0]             rq [2];
  logic signed [RQW-1:0]             rlane [2];
  logic signed [pbg_pkg::SIZE_W:0]   sz_s;
  logic signed [pbg_pkg::HALF_LO_W:0] lo_s;
  logic signed [pbg_pkg::HALF_W-pbg_pkg::HALF_LO_W:0] hi_s;
  logic signed [PSX-1:0]             psx [2];
  logic signed [HCX-1:0]             hcx [2];
  logic signed [OUX-1:0]             oux [2];
  logic signed [SW-1:0]              diff [2];

  always_comb begin
    vin[0] = c_i;
    vin[1] = s_i;
    sz_s   = $signed({1'b0, det_size_i});
    lo_s   = $signed({1'b0, half_i[pbg_pkg::HALF_LO_W-1:0]});
    hi_s   = $signed({1'b0, half_i[pbg_pkg::HALF_W-1:pbg_pkg::HALF_LO_W]});
    for (int k = 0; k < 2; k++) begin
      // stage 1
      psz_d[k] = sz_s * vin[k];
      plo_d[k] = lo_s * vin[k];
      phi_d[k] = hi_s * vin[k];
      rq[k]    = ((RQW'(vin[k]) + RQ_RND) >>> RSH) <<< LSH;
      // stage 2
      psx[k]   = (PSX'(psz_q[k]) + UX_RND) >>> FRAC_BITS;
      ux2_d[k] = UW'(psx[k]);
      hc2_d[k] = (HCW'(phi_q[k]) <<< pbg_pkg::HALF_LO_W) + HCW'(plo_q[k]);
      // stage 3
      ou3_d[k] = off2_q * ux2_q[k];
      hcx[k]   = (HCX'(hc2_q[k]) + HC_RND) >>> (FRAC_BITS + 1);
      hcr3_d[k] = SW'(hcx[k]);
      if (ux2_q[k] > STEP_HI) begin
        step3_d[k] = pbg_pkg::STEP_W'(STEP_HI);
      end else if (ux2_q[k] < STEP_LO) begin
        step3_d[k] = pbg_pkg::STEP_W'(STEP_LO);
      end else begin
        step3_d[k] = pbg_pkg::STEP_W'(ux2_q[k]);
      end
      // stage 4
      oux[k]    = (OUX'(ou3_q[k]) + OU_RND) >>> pbg_pkg::OFF_FRAC;
      ofr4_d[k] = SW'(oux[k]);
      // stage 5
      diff[k] = -hcr4_q[k] - ofr4_q[k];
      if (diff[k] > pbg_pkg::START_HI) begin
        start5_d[k] = pbg_pkg::START_W'(pbg_pkg::START_HI);
      end else if (diff[k] < pbg_pkg::START_LO) begin
        start5_d[k] = pbg_pkg::START_W'(pbg_pkg::START_LO);
      end else begin
        start5_d[k] = pbg_pkg::START_W'(diff[k]);
      end
    end
    // ray x is -s, ray y is c
    rlane[0] = -rq[1];
    rlane[1] = rq[0];
    for (int k = 0; k < 2; k++) begin
      if (rlane[k] > RAY_HI) begin
        ray1_d[k] = pbg_pkg::RAY_W'(RAY_HI);
      end else if (rlane[k] < RAY_LO) begin
        ray1_d[k] = pbg_pkg::RAY_W'(RAY_LO);
      end else begin
        ray1_d[k] = pbg_pkg::RAY_W'(rlane[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      psz_q    <= psz_d;
      plo_q    <= plo_d;
      phi_q    <= phi_d;
      ray1_q   <= ray1_d;
      off1_q   <= det_offset_i;
      last1_q  <= last_i;

      ux2_q    <= ux2_d;
      hc2_q    <= hc2_d;
      ray2_q   <= ray1_q;
      off2_q   <= off1_q;
      last2_q  <= last1_q;

      ou3_q    <= ou3_d;
      hcr3_q   <= hcr3_d;
      step3_q  <= step3_d;
      ray3_q   <= ray2_q;
      last3_q  <= last2_q;

      ofr4_q   <= ofr4_d;
      hcr4_q   <= hcr3_q;
      step4_q  <= step3_q;
      ray4_q   <= ray3_q;
      last4_q  <= last3_q;

      start5_q <= start5_d;
      step5_q  <= step4_q;
      ray5_q   <= ray4_q;
      last5_q  <= last4_q;
    end
  end

  assign valid_o   = vld_q[4];
  assign ray_x_o   = ray5_q[0];
  assign ray_y_o   = ray5_q[1];
  assign start_x_o = start5_q[0];
  assign start_y_o = start5_q[1];
  assign step_x_o  = step5_q[0];
  assign step_y_o  = step5_q[1];
  assign last_o    = last5_q;

endmodule

// File: src/parallel_beam_geometry_gen_core.sv
`timescale 1ns / 1ps
// channel | dir | handshake        | payload
// in_i    | in  | valid / ready    | angle, det_offset, last_view
// out_o   | out | valid / ready    | ray_x/y, start_x/y, step_x/y, last_out
// cfg_i   | in  | valid / ready(1) | index, data
//
// one view per cycle while the output is not stalled; the pipeline is one cell per CORDIC
// iteration, a rounding/quadrant stage, then five multiply and rounding stages
// when the output register holds a result that is not taken, the whole pipeline
// freezes and in_i.ready drops
// reset clears the valid bits and loads det_count = 512, det_size = 1.0
// the config port always accepts; det_count * det_size is re-registered each cycle
`include "parallel_beam_geometry_gen_core_defines.svh"
module parallel_beam_geometry_gen_core #(
  parameter int ANGLE_BITS   = 16,
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pbg_in_if.sink     in_i,
  pbg_out_if.source  out_o,
  pbg_cfg_if.sink    cfg_i
);

  localparam int CW  = FRAC_BITS + 3;
  localparam int RS  = pbg_pkg::WORK_FRAC - FRAC_BITS;
  localparam int ZSH = pbg_pkg::WORK_W - ANGLE_BITS;
  localparam int XW  = pbg_pkg::WORK_W + 2;
  localparam logic signed [XW-1:0] CRD_RND = (XW'(1) << RS) >> 1;

  logic                               en;
  logic [pbg_pkg::COUNT_W-1:0]        det_count_q;
  logic [pbg_pkg::SIZE_W-1:0]         det_size_q;
  logic [pbg_pkg::HALF_W-1:0]         half_q;

  logic [ANGLE_BITS-1:0]              ang;
  pbg_pkg::cordic_t                   chain [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0]              chain_vld;
  pbg_pkg::cordic_t                   tail;

  logic signed [XW-1:0]               xr;
  logic signed [XW-1:0]               yr;
  logic signed [CW-1:0]               cx;
  logic signed [CW-1:0]               sy;
  logic signed [CW-1:0]               c_d;
  logic signed [CW-1:0]               s_d;
  logic                               q_valid_q;
  logic signed [CW-1:0]               c_q;
  logic signed [CW-1:0]               s_q;
  logic signed [pbg_pkg::OFFSET_W-1:0] off_q;
  logic                               last_q;

  // pipeline advances unless a finished result is waiting
  assign en          = !out_o.valid || out_o.ready;
  assign in_i.ready  = en;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_count_q <= pbg_pkg::DET_COUNT_RST;
      det_size_q  <= pbg_pkg::DET_SIZE_RST;
      half_q      <= pbg_pkg::HALF_RST;
    end else begin
      half_q <= pbg_pkg::HALF_W'(det_count_q) * pbg_pkg::HALF_W'(det_size_q);
      if (cfg_i.valid) begin
        if (cfg_i.index == pbg_pkg::REG_DET_COUNT) begin
          det_count_q <= cfg_i.data[pbg_pkg::COUNT_W-1:0];
        end else if (cfg_i.index == pbg_pkg::REG_DET_SIZE) begin
          det_size_q <= cfg_i.data[pbg_pkg::SIZE_W-1:0];
        end
      end
    end
  end

  // head of the chain: quadrant split and residual angle in 2^-32 turn
  always_comb begin
    ang                 = ANGLE_BITS'(in_i.angle);
    chain[0].x          = pbg_pkg::GAIN_INV;
    chain[0].y          = '0;
    chain[0].z          = $signed(pbg_pkg::WORK_W'(ang[ANGLE_BITS-3:0]) << ZSH);
    chain[0].quad       = pbg_pkg::quad_e'(ang[ANGLE_BITS-1 -: 2]);
    chain[0].det_offset = in_i.det_offset;
    chain[0].last       = in_i.last_view;
  end
  assign chain_vld[0] = in_i.valid;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    pbg_cordic_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (chain_vld[i]),
      .data_i  (chain[i]),
      .valid_o (chain_vld[i+1]),
      .data_o  (chain[i+1])
    );
  end

  always_comb begin
    tail = chain[CORDIC_STEPS];
    xr   = (XW'(tail.x) + CRD_RND) >>> RS;
    yr   = (XW'(tail.y) + CRD_RND) >>> RS;
    cx   = CW'(xr);
    sy   = CW'(yr);
    case (tail.quad)
      pbg_pkg::QUAD_0: begin
        c_d = cx;
        s_d = sy;
      end
      pbg_pkg::QUAD_1: begin
        c_d = -sy;
        s_d = cx;
      end
      pbg_pkg::QUAD_2: begin
        c_d = -cx;
        s_d = -sy;
      end
      default: begin
        c_d = sy;
        s_d = -cx;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_valid_q <= 1'b0;
    end else if (en) begin
      q_valid_q <= chain_vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q    <= c_d;
      s_q    <= s_d;
      off_q  <= tail.det_offset;
      last_q <= tail.last;
    end
  end

  pbg_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (q_valid_q),
    .c_i          (c_q),
    .s_i          (s_q),
    .det_offset_i (off_q),
    .last_i       (last_q),
    .det_size_i   (det_size_q),
    .half_i       (half_q),
    .valid_o      (out_o.valid),
    .ray_x_o      (out_o.ray_x),
    .ray_y_o      (out_o.ray_y),
    .start_x_o    (out_o.start_x),
    .start_y_o    (out_o.start_y),
    .step_x_o     (out_o.step_x),
    .step_y_o     (out_o.step_y),
    .last_o       (out_o.last_out)
  );

  `PBG_ASSERT_SAME(a_stall_blocks_input, clk_i, rst_ni,
    out_o.valid && !out_o.ready, !in_i.ready, "input taken while output stalled")
  `PBG_ASSERT_NEXT(a_stall_freezes_pipe, clk_i, rst_ni,
    !in_i.ready, $stable(q_valid_q) && $stable(chain_vld[CORDIC_STEPS:1]),
    "pipeline moved during stall")
  `PBG_ASSERT_SAME(a_ray_in_range, clk_i, rst_ni, out_o.valid,
    ($signed(out_o.ray_x) <= 18'sd65536) && ($signed(out_o.ray_x) >= -18'sd65536) &&
    ($signed(out_o.ray_y) <= 18'sd65536) && ($signed(out_o.ray_y) >= -18'sd65536),
    "ray outside unit range")
  `PBG_ASSERT_SAME(a_step_in_range, clk_i, rst_ni, out_o.valid,
    ($signed(out_o.step_x) <= 26'sd16777216) && ($signed(out_o.step_x) >= -26'sd16777216) &&
    ($signed(out_o.step_y) <= 26'sd16777216) && ($signed(out_o.step_y) >= -26'sd16777216),
    "step outside range")

endmodule
